/* rtl/core/rwc_pkg.sv */
// Shared types and constants of the rotating word checksum block.
`timescale 1ns / 1ps

package rwc_pkg;

    // Constants of the checksum arithmetic.
    localparam logic [15:0] ADD_CONST   = 16'hDAAC;
    localparam logic [15:0] FINAL_SUB   = 16'h8631;
    localparam logic [15:0] FINAL_XOR   = 16'hDF9B;
    localparam logic [3:0]  NIBBLE_MASK = 4'hF;

    // Configuration register indexes.
    localparam logic CFG_SEED_LOW  = 1'b0;
    localparam logic CFG_SEED_HIGH = 1'b1;

    // The four phases of the word sequence.
    typedef enum logic [1:0] {
        PHASE_XOR_ROL = 2'd0,
        PHASE_SUB_XOR = 2'd1,
        PHASE_SUB_ADD = 2'd2,
        PHASE_XOR_ROR = 2'd3
    } t_phase;

    // One input request.
    typedef struct packed {
        logic [15:0] data_word;
        logic        first_word;
        logic        last_word;
    } t_in_item;

    // One result request.
    typedef struct packed {
        logic [31:0] checksum;
        logic        odd_length_error;
    } t_out_item;

    // Running state carried from word to word.
    typedef struct packed {
        logic [15:0] acc_low;
        logic [15:0] acc_high;
        t_phase      phase;
        logic        rotate_carry;
    } t_state;

endpackage

/* rtl/core/rwc_step.sv */
// Combinational update of the checksum state for one word, with finalization.
`timescale 1ns / 1ps

module rwc_step (
    input  rwc_pkg::t_state    i_state,
    input  rwc_pkg::t_in_item  i_item,
    input  logic [15:0]        i_seed_low,
    input  logic [15:0]        i_seed_high,
    output rwc_pkg::t_state    o_state,
    output rwc_pkg::t_out_item o_result
);
    import rwc_pkg::*;

    always_comb begin
        t_state      base;
        t_state      nxt;
        logic [31:0] rot;
        logic [3:0]  amt;
        logic [1:0]  phase_bits;
        logic [15:0] final_low;
        logic [15:0] final_high;

        // A start mark reloads the seeds before the word is applied.
        base = i_state;
        if (i_item.first_word) begin
            base.acc_low      = i_seed_low;
            base.acc_high     = i_seed_high;
            base.phase        = PHASE_XOR_ROL;
            base.rotate_carry = 1'b0;
        end

        nxt = base;
        rot = 32'h0;
        amt = 4'h0;

        // Apply the word according to the current phase.
        case (base.phase)
            PHASE_XOR_ROL: begin
                amt = base.acc_high[3:0] & NIBBLE_MASK;
                rot = {base.acc_low ^ i_item.data_word, base.acc_low ^ i_item.data_word} << amt;
                nxt.acc_low      = rot[31:16];
                nxt.rotate_carry = (amt != 4'h0) ? rot[16] : 1'b0;
            end
            PHASE_SUB_XOR: begin
                nxt.acc_high = (base.acc_high - i_item.data_word
                                - {15'h0, base.rotate_carry}) ^ base.acc_low;
            end
            PHASE_SUB_ADD: begin
                nxt.acc_low = base.acc_low - i_item.data_word + ADD_CONST;
            end
            PHASE_XOR_ROR: begin
                amt = base.acc_low[3:0] & NIBBLE_MASK;
                rot = {base.acc_high ^ i_item.data_word, base.acc_high ^ i_item.data_word} >> amt;
                nxt.acc_high = rot[15:0];
            end
            default: begin
                nxt = base;
            end
        endcase

        // The phase advances by one, and returns to the start after a block end.
        phase_bits = base.phase;
        phase_bits = phase_bits + 2'd1;
        nxt.phase  = i_item.last_word ? PHASE_XOR_ROL : t_phase'(phase_bits);

        // Finalize from the updated accumulators.
        final_low  = nxt.acc_low - FINAL_SUB + ADD_CONST;
        final_high = nxt.acc_high ^ FINAL_XOR;

        o_state                   = nxt;
        o_result.checksum         = {final_high, final_low};
        o_result.odd_length_error = (base.phase == PHASE_XOR_ROL)
                                    || (base.phase == PHASE_SUB_ADD);
    end

endmodule

/* rtl/core/rotating_word_checksum32.sv */
// A word accepted into the input register is applied from there to the state register; a
// last word's result is loaded into an output register and held there until taken.
// Throughput: one word per cycle, set by the single update step between the input
// register and the state and result registers; a waiting result stalls only last words.
// Reset: synchronous, active low; clears accumulators, phase, carry, seeds and valid flags.
`timescale 1ns / 1ps

module rotating_word_checksum32 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rwc_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rwc_pkg::t_out_item o_out,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import rwc_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in;
    t_state      r_state;
    t_state      n_state;
    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   n_out;
    logic [15:0] r_seed_low;
    logic [15:0] r_seed_high;
    logic        w_out_free;
    logic        w_advance;

    // The held word is applied when it needs no result slot or one is free.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && (!r_in.last_word || w_out_free);
    assign o_in_ready = !r_in_valid || w_advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_low  <= 16'h0;
            r_seed_high <= 16'h0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEED_LOW:  r_seed_low  <= i_cfg_data;
                CFG_SEED_HIGH: r_seed_high <= i_cfg_data;
                default:       r_seed_low  <= r_seed_low;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Word update and finalization.
    rwc_step u_step (
        .i_state     (r_state),
        .i_item      (r_in),
        .i_seed_low  (r_seed_low),
        .i_seed_high (r_seed_high),
        .o_state     (n_state),
        .o_result    (n_out)
    );

    // Running state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{acc_low: 16'h0, acc_high: 16'h0, phase: PHASE_XOR_ROL,
                         rotate_carry: 1'b0};
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in.last_word) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in.last_word) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    // A result appears only after a last word has been applied.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_advance && r_in.last_word))
        else $error("result raised without a last word");

    // A block end leaves the phase at the start.
    a_phase_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.last_word) |=> (r_state.phase == PHASE_XOR_ROL))
        else $error("phase not restarted after block end");

    // A block end always leaves a result waiting.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.last_word) |=> o_out_valid)
        else $error("block end without a result");

    // A last word is never applied over a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.last_word && r_out_valid) |-> i_out_ready)
        else $error("result overwritten before it was taken");
`endif

endmodule

/* dv/tb_rotating_word_checksum32.sv */
// Self-checking testbench for the rotating word checksum block with a predicting scoreboard.
`timescale 1ns / 1ps

module tb_rotating_word_checksum32;

    import rwc_pkg::*;

    // Predicts the checksum of each block from the accepted word requests and
    // checks the result requests against the predictions in order.
    class checksum_predictor;
        logic [15:0] seed_low;
        logic [15:0] seed_high;
        logic [15:0] acc_low;
        logic [15:0] acc_high;
        t_phase      phase;
        logic        carry;
        t_out_item   expected_sums[$];
        int          mismatches;

        function new();
            seed_low    = '0;
            seed_high   = '0;
            acc_low     = '0;
            acc_high    = '0;
            phase       = PHASE_XOR_ROL;
            carry       = 1'b0;
            mismatches  = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function void set_seed(logic idx, logic [15:0] value);
            if (idx == CFG_SEED_LOW) begin
                seed_low = value;
            end else begin
                seed_high = value;
            end
        endfunction

        // Applies one word to the accumulators and queues a checksum on a last word.
        function void absorb_word(t_in_item item);
            logic [15:0] w;
            logic [31:0] doubled;
            logic [1:0]  next_phase;
            t_phase      cur;
            t_out_item   res;
            w = item.data_word;
            if (item.first_word) begin
                acc_low  = seed_low;
                acc_high = seed_high;
                phase    = PHASE_XOR_ROL;
                carry    = 1'b0;
            end
            cur = phase;
            case (cur)
                PHASE_XOR_ROL: begin
                    acc_low = acc_low ^ w;
                    carry   = 1'b0;
                    if (acc_high[3:0] != 4'd0) begin
                        doubled = {acc_low, acc_low} << acc_high[3:0];
                        acc_low = doubled[31:16];
                        carry   = acc_low[0];
                    end
                end
                PHASE_SUB_XOR: begin
                    acc_high = acc_high - w - {15'd0, carry};
                    acc_high = acc_high ^ acc_low;
                end
                PHASE_SUB_ADD: begin
                    acc_low = acc_low - w + ADD_CONST;
                end
                default: begin
                    acc_high = acc_high ^ w;
                    doubled  = {acc_high, acc_high} >> acc_low[3:0];
                    acc_high = doubled[15:0];
                end
            endcase
            next_phase = cur + 2'd1;
            phase      = t_phase'(next_phase);
            if (item.last_word) begin
                res.checksum         = {acc_high ^ FINAL_XOR, acc_low - FINAL_SUB + ADD_CONST};
                res.odd_length_error = (cur == PHASE_XOR_ROL) || (cur == PHASE_SUB_ADD);
                expected_sums.push_back(res);
                phase = PHASE_XOR_ROL;
            end
        endfunction

        // Compares one result request with the oldest prediction.
        task match_result(t_out_item got);
            t_out_item want;
            if (expected_sums.size() == 0) begin
                report($sformatf("unexpected result checksum=%h err=%b",
                                 got.checksum, got.odd_length_error));
            end else begin
                want = expected_sums.pop_front();
                if (got.checksum !== want.checksum) begin
                    report($sformatf("checksum %h, expected %h", got.checksum, want.checksum));
                end
                if (got.odd_length_error !== want.odd_length_error) begin
                    report($sformatf("odd_length_error %b, expected %b",
                                     got.odd_length_error, want.odd_length_error));
                end
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    checksum_predictor sb;
    int                send_idle_pct;
    int                recv_idle_pct;

    rotating_word_checksum32 uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5_000_000;
        $display("rotating_word_checksum32 verification failed");
        $finish;
    end

    // Result side: random back-pressure driven at the falling edge.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result side: check each accepted result request at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.match_result(o_out);
        end
    end

    // Presents one word request, with random gaps before it, and waits for acceptance.
    task send_word(logic [15:0] w, logic first, logic last);
        t_in_item item;
        item.data_word  = w;
        item.first_word = first;
        item.last_word  = last;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (!o_in_ready);
        sb.absorb_word(item);
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_sums.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_seed(logic idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_seed(idx, value);
    endtask

    // Biased towards the all-zero and all-one words.
    function automatic logic [15:0] random_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly well-formed blocks of even length, with broken blocks and loose words mixed in.
    task run_random(int n_items);
        int sent;
        int kind;
        int len;
        int i;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                len = 2 * $urandom_range(1, 6);
            end else if (kind == 7) begin
                len = 2 * $urandom_range(0, 3) + 1;
            end else begin
                len = $urandom_range(1, 4);
            end
            for (i = 0; i < len; i++) begin
                if (kind <= 7) begin
                    send_word(random_word(), i == 0, i == len - 1);
                end else if (kind == 8) begin
                    send_word(random_word(), 1'b0, $urandom_range(0, 3) == 0);
                end else begin
                    send_word(random_word(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end
            end
            sent += len;
        end
    endtask

    // Main sequence.
    initial begin
        int i;
        sb            = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in          = '0;
        i_out_ready   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_SEED_LOW;
        i_cfg_data    = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Words without a start mark straight after reset, ending on a valid phase.
        send_word(16'hFFFF, 1'b0, 1'b0);
        send_word(16'h0000, 1'b0, 1'b1);
        settle();

        // Seeds at their maximum; a four-word block ends on a valid phase.
        write_seed(CFG_SEED_LOW, 16'hFFFF);
        write_seed(CFG_SEED_HIGH, 16'hFFFF);
        send_word(16'h0000, 1'b1, 1'b0);
        send_word(16'hFFFF, 1'b0, 1'b0);
        send_word(16'h8000, 1'b0, 1'b0);
        send_word(16'h0001, 1'b0, 1'b1);

        // A single-word block is an invalid end.
        send_word(16'hA5A5, 1'b1, 1'b1);

        // Words continue after a block end without a start mark; three words end badly.
        send_word(16'h1234, 1'b0, 1'b0);
        send_word(16'h5A5A, 1'b0, 1'b0);
        send_word(16'hFFFF, 1'b0, 1'b1);
        settle();

        // Zero seeds: no rotation in the opening phase.
        write_seed(CFG_SEED_LOW, 16'h0000);
        write_seed(CFG_SEED_HIGH, 16'h0000);
        send_word(16'h0000, 1'b1, 1'b0);
        send_word(16'hFFFF, 1'b0, 1'b1);
        settle();

        // The usual seed pair; an eight-word block then a three-word block.
        write_seed(CFG_SEED_LOW, 16'h8631);
        write_seed(CFG_SEED_HIGH, 16'hEFCD);
        for (i = 0; i < 8; i++) begin
            send_word(random_word(), i == 0, i == 7);
        end
        for (i = 0; i < 3; i++) begin
            send_word(random_word(), i == 0, i == 2);
        end
        settle();

        // Random traffic, first with a slow receiver.
        write_seed(CFG_SEED_LOW, 16'($urandom));
        write_seed(CFG_SEED_HIGH, 16'($urandom));
        send_idle_pct = 12;
        recv_idle_pct = 66;
        run_random(630);
        settle();

        // Then with a slow sender.
        write_seed(CFG_SEED_LOW, 16'h0000);
        write_seed(CFG_SEED_HIGH, 16'hFFFF);
        send_idle_pct = 66;
        recv_idle_pct = 12;
        run_random(630);
        settle();

        // Then back to back.
        write_seed(CFG_SEED_LOW, 16'($urandom));
        write_seed(CFG_SEED_HIGH, 16'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(640);
        settle();

        if (sb.mismatches == 0) begin
            $display("rotating_word_checksum32 verification clean");
        end else begin
            $display("rotating_word_checksum32 verification failed");
        end
        $finish;
    end

endmodule
